// ----- src/sit_pkg.sv -----
// Package for the safe interval table: sizes, codes and item types.
// Used by safe_interval_table and its checker; depends on nothing.
package sit_pkg;
  localparam int unsigned Locations = 16;
  localparam int unsigned Slots     = 16;
  localparam int unsigned Horizon   = 65535;
  localparam int unsigned LocW      = $clog2(Locations);
  localparam int unsigned SlotW     = $clog2(Slots);
  localparam int unsigned CntW      = $clog2(Slots + 1);
  localparam int unsigned AddrW     = LocW + SlotW;
  localparam int unsigned TimeW     = 17;

  localparam logic [1:0] OpInit     = 2'd0;
  localparam logic [1:0] OpSubtract = 2'd1;
  localparam logic [1:0] OpFind     = 2'd2;
  localparam logic [1:0] OpUndef    = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StOverflow = 2'd2;
  localparam logic [1:0] StBadRange = 2'd3;

  typedef struct packed {
    logic [1:0]       operation;
    logic [3:0]       location;
    logic [TimeW-1:0] t_low;
    logic [TimeW-1:0] t_high;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [TimeW-1:0] interval_low;
    logic [TimeW-1:0] interval_high;
  } res_t;
endpackage

// ----- src/safe_interval_table.sv -----
// Safe interval table top level: interval memory and its sequencer.
// Depends on sit_pkg.
//
// An item is taken on start while busy is low; busy rises in the next cycle
// and stays high until the one result appears on res_o with done_o for one
// cycle, by which time busy is low again. The receiver cannot stall, so a
// result is never held back.
// The interval lists live in one memory of Locations*Slots entries (start and
// end of each interval), read through a registered output.
// Init, bad items, finds past the limit and items on an empty list go straight
// to the result; find reads the intervals in turn until one holds the start or
// lies past it; subtract reads every stored interval and writes back what is
// left of it, with one more write when it splits one. On a full list the
// subtract first scans the entries for a split that cannot fit, before any write.
// The per-location counts reset to zero, so every list is empty after reset;
// memory entries are never read before written. lmax_q is written by
// cfg_we_i with cfg_wdata_i and resets to 65535.
module safe_interval_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  sit_pkg::cmd_t cmd_i,
  output logic          done_o,
  output sit_pkg::res_t res_o,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i
);
  import sit_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHKRD, S_CHK, S_RD, S_WALK, S_FLUSH, S_FINRD, S_FIN, S_DONE
  } state_e;

  state_e           state_q;
  logic [15:0]      lmax_q;
  cmd_t             cmd_q;
  logic [CntW-1:0]  cnt_q [Locations];
  logic [CntW-1:0]  idx_q, k_q;
  logic [1:0]       st_q;
  logic [TimeW-1:0] olo_q, ohi_q;
  logic             pend_q;   // an entry still to write behind a split
  logic [TimeW-1:0] ps_q, pe_q;

  logic [2*TimeW-1:0] mem [Locations*Slots];
  logic [2*TimeW-1:0] rd_q;

  logic [TimeW-1:0] limit;
  assign limit = (lmax_q > 16'(Horizon - 1)) ? TimeW'(Horizon) : TimeW'(lmax_q) + 1'b1;

  logic [CntW-1:0] n;
  assign n = cnt_q[cmd_q.location];
  logic [TimeW-1:0] s, e, lo, hi;
  assign s  = rd_q[2*TimeW-1:TimeW];
  assign e  = rd_q[TimeW-1:0];
  assign lo = cmd_q.t_low;
  assign hi = cmd_q.t_high;

  function automatic logic [AddrW-1:0] addr(logic [LocW-1:0] l, logic [CntW-1:0] i);
    return {l, i[SlotW-1:0]};
  endfunction

  // Memory: one write and one registered read per cycle.
  logic             we, re;
  logic [AddrW-1:0] wa, ra;
  logic [2*TimeW-1:0] wd;
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  always_comb begin
    re = 1'b0; ra = addr(cmd_q.location, idx_q);
    we = 1'b0; wa = addr(cmd_q.location, k_q); wd = {ps_q, pe_q};
    if (state_q == S_CHKRD || state_q == S_RD || state_q == S_FINRD) re = 1'b1;
    if (state_q == S_IDLE && start && cmd_i.operation == OpInit) begin
      we = 1'b1; wa = addr(cmd_i.location, '0); wd = {TimeW'(0), limit};
    end
    if ((state_q == S_WALK && pend_q) || state_q == S_FLUSH) we = 1'b1;
    if (state_q == S_WALK && !pend_q) begin
      we = 1'b1;
      if (lo >= e || hi <= s) wd = {s, e};
      else if (s < lo)        wd = {s, lo};
      else if (hi < e)        wd = {hi, e};
      else                    we = 1'b0;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lmax_q  <= 16'hFFFF;
      for (int i = 0; i < Locations; i++) cnt_q[i] <= '0;
      done_o  <= 1'b0;
      res_o   <= '0;
      cmd_q   <= '0;
      idx_q <= '0; k_q <= '0; pend_q <= 1'b0; st_q <= StOk;
      olo_q <= '0; ohi_q <= '0; ps_q <= '0; pe_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) lmax_q <= cfg_wdata_i;
      unique case (state_q)
        S_IDLE: if (start) begin
          cmd_q <= cmd_i; idx_q <= '0; k_q <= '0; pend_q <= 1'b0;
          olo_q <= '0; ohi_q <= '0; st_q <= StOk;
          state_q <= S_DONE;
          if (cmd_i.operation == OpUndef) st_q <= StBadRange;
          else if (cmd_i.operation == OpInit) cnt_q[cmd_i.location] <= CntW'(1);
          else if (cmd_i.operation == OpSubtract) begin
            if (cmd_i.t_low >= cmd_i.t_high) st_q <= StBadRange;
            else if (cnt_q[cmd_i.location] >= CntW'(Slots)) state_q <= S_CHKRD;
            else if (cnt_q[cmd_i.location] != '0) state_q <= S_RD;
          end else begin
            st_q <= StNotFound;
            if (cmd_i.t_low < limit && cnt_q[cmd_i.location] != '0) state_q <= S_FINRD;
          end
        end
        // Full list: refuse any split before writing the memory.
        S_CHKRD: state_q <= S_CHK;
        S_CHK: begin
          if (s < lo && hi < e) begin
            st_q <= StOverflow; state_q <= S_DONE;
          end else if (idx_q + 1'b1 >= n) begin
            idx_q <= '0; state_q <= S_RD;
          end else begin
            idx_q <= idx_q + 1'b1; state_q <= S_CHKRD;
          end
        end
        S_RD: state_q <= S_WALK;
        // Behind a split every entry moves up one slot: carry each one in
        // ps/pe and write it a step later, into a slot that is already read.
        S_WALK: begin
          if (pend_q) begin
            k_q <= k_q + 1'b1; ps_q <= s; pe_q <= e;
          end else if (lo >= e || hi <= s || !(lo <= s && e <= hi)) begin
            k_q <= k_q + 1'b1;
            if (s < lo && hi < e) begin
              pend_q <= 1'b1; ps_q <= hi; pe_q <= e;
            end
          end
          if (idx_q + 1'b1 >= n) begin
            if (pend_q || (s < lo && hi < e)) begin
              state_q <= S_FLUSH;
            end else begin
              state_q <= S_DONE;
              cnt_q[cmd_q.location] <= (lo >= e || hi <= s || !(lo <= s && e <= hi))
                                       ? k_q + 1'b1 : k_q;
            end
          end else begin
            idx_q <= idx_q + 1'b1; state_q <= S_RD;
          end
        end
        S_FLUSH: begin
          pend_q <= 1'b0; cnt_q[cmd_q.location] <= k_q + 1'b1; state_q <= S_DONE;
        end
        S_FINRD: state_q <= S_FIN;
        S_FIN: begin
          if (s <= lo && lo < e) begin
            st_q <= StOk; olo_q <= lo; ohi_q <= e; state_q <= S_DONE;
          end else if (lo < s || idx_q + 1'b1 >= n) state_q <= S_DONE;
          else begin
            idx_q <= idx_q + 1'b1; state_q <= S_FINRD;
          end
        end
        S_DONE: begin
          done_o <= 1'b1;
          res_o  <= '{status: st_q, interval_low: olo_q, interval_high: ohi_q};
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- src/sit_checker.sv -----
// Port-level checker for safe_interval_table, bound to the top level.
// Depends on sit_pkg.
module sit_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input sit_pkg::res_t res_o
);
  import sit_pkg::*;

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("item taken but busy low");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while still busy");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result repeated");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status != StOk |-> res_o.interval_high == '0)
    else $error("payload on failed item");
endmodule

bind safe_interval_table sit_checker u_sit_checker (.*);

// ----- test/sit_checker.sv -----
// Checker for the safe interval table: watches commands, config writes and
// results, keeps its own copy of the interval lists and compares each result.
// Depends on sit_pkg.
module sit_scoreboard (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  sit_pkg::cmd_t cmd_i,
  input  logic          done_o,
  input  sit_pkg::res_t res_o,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  output int            errors,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sit_pkg::*;

  logic [TimeW-1:0] iv_lo [Locations*Slots];
  logic [TimeW-1:0] iv_hi [Locations*Slots];
  int               iv_cnt [Locations];
  logic [15:0]      limit_reg;
  res_t             awaited_q [$];

  function automatic logic [TimeW-1:0] horizon_end();
    logic [TimeW-1:0] l;
    l = (limit_reg > Horizon - 1) ? TimeW'(Horizon - 1) : TimeW'(limit_reg);
    return l + 1'b1;
  endfunction

  function automatic logic [1:0] cut_range(int loc, logic [TimeW-1:0] lo,
                                           logic [TimeW-1:0] hi);
    logic [TimeW-1:0] ns [Slots+1];
    logic [TimeW-1:0] ne [Slots+1];
    logic [TimeW-1:0] s, e;
    int base, n, k;
    base = loc * Slots;
    n    = iv_cnt[loc];
    k    = 0;
    for (int i = 0; i < n; i++) begin
      if (iv_lo[base+i] < lo && hi < iv_hi[base+i] && n >= Slots) return StOverflow;
    end
    for (int i = 0; i < n; i++) begin
      s = iv_lo[base+i];
      e = iv_hi[base+i];
      if (lo >= e || hi <= s) begin
        ns[k] = s; ne[k] = e; k++;
      end else if (s < lo && e <= hi) begin
        ns[k] = s; ne[k] = lo; k++;
      end else if (lo <= s && hi < e) begin
        ns[k] = hi; ne[k] = e; k++;
      end else if (s < lo && hi < e) begin
        ns[k] = s; ne[k] = lo; k++;
        ns[k] = hi; ne[k] = e; k++;
      end
      if (k > Slots) return StOverflow;
    end
    for (int i = 0; i < k; i++) begin
      iv_lo[base+i] = ns[i];
      iv_hi[base+i] = ne[i];
    end
    iv_cnt[loc] = k;
    return StOk;
  endfunction

  function automatic res_t apply_cmd(cmd_t c);
    res_t r;
    int   loc, base;
    r    = '0;
    loc  = c.location;
    base = loc * Slots;
    case (c.operation)
      OpInit: begin
        iv_lo[base] = '0;
        iv_hi[base] = horizon_end();
        iv_cnt[loc] = 1;
        r.status    = StOk;
      end
      OpSubtract: begin
        if (c.t_low >= c.t_high) r.status = StBadRange;
        else r.status = cut_range(loc, c.t_low, c.t_high);
      end
      OpFind: begin
        r.status = StNotFound;
        if (c.t_low < horizon_end()) begin
          for (int i = 0; i < iv_cnt[loc]; i++) begin
            if (iv_lo[base+i] <= c.t_low && c.t_low < iv_hi[base+i]) begin
              r.status        = StOk;
              r.interval_low  = c.t_low;
              r.interval_high = iv_hi[base+i];
              break;
            end
            if (c.t_low < iv_lo[base+i]) break;
          end
        end
      end
      default: r.status = StBadRange;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      limit_reg = 16'hFFFF;
      for (int i = 0; i < Locations; i++) iv_cnt[i] = 0;
      awaited_q.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (done_o) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: result with none awaited, actual %p", $time, res_o);
          errors <= errors + 1;
        end else begin
          want = awaited_q.pop_front();
          if (want.status !== res_o.status || want.interval_low !== res_o.interval_low ||
              want.interval_high !== res_o.interval_high) begin
            $display("%0t: expected %p, actual %p", $time, want, res_o);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_we_i) limit_reg = cfg_wdata_i;
      if (start && !busy) awaited_q.push_back(apply_cmd(cmd_i));
      pending <= awaited_q.size();
    end
  end
endmodule

// ----- test/tb_safe_interval_table.sv -----
// Testbench top for the safe interval table: clock, reset, command stimulus
// and config writes; checking lives in sit_scoreboard. Depends on sit_pkg.
module tb_safe_interval_table;
  timeunit 1ns;
  timeprecision 1ps;
  import sit_pkg::*;

  localparam int Drain = 80;
  localparam int CmdW  = $bits(cmd_t);

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd_i = '0;
  logic        done_o;
  res_t        res_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  int          errors, pending;
  int          idle_pct;
  int          span;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  safe_interval_table u_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .done_o, .res_o, .cfg_we_i, .cfg_wdata_i
  );

  sit_scoreboard u_chk (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .done_o, .res_o, .cfg_we_i, .cfg_wdata_i,
    .errors, .pending
  );

  task automatic issue(logic [1:0] op, int loc, int lo, int hi);
    cmd_t c;
    c.operation = op;
    c.location  = 4'(loc);
    c.t_low     = 17'(lo);
    c.t_high    = 17'(hi);
    // idle each cycle at random
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      cmd_i <= cmd_t'(CmdW'({$urandom, $urandom}));
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [15:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    span        = (v > Horizon - 1) ? Horizon : v + 1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_item();
    int r, lo, w, hi;
    r  = $urandom_range(99);
    lo = ($urandom_range(9) == 0) ? $urandom_range(65536) : $urandom_range(span + 1);
    w  = ($urandom_range(3) == 0) ? $urandom_range(1, span + 1) : $urandom_range(1, 8);
    if ($urandom_range(19) == 0) w = -$urandom_range(0, 3);
    hi = lo + w;
    if (hi > 65536) hi = 65536;
    if (hi < 0) hi = 0;
    if (r < 8)       issue(OpInit, $urandom_range(15), lo, $urandom_range(65536));
    else if (r < 58) issue(OpSubtract, $urandom_range(15), lo, hi);
    else if (r < 95) issue(OpFind, $urandom_range(15), lo, $urandom_range(65536));
    else             issue(OpUndef, $urandom_range(15), lo, hi);
  endtask

  initial begin
    idle_pct = 27;
    span     = Horizon;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty lists, bounds, bad items, every kind of cut, overflow
    issue(OpSubtract, 15, 3, 9);
    issue(OpFind, 15, 0, 0);
    issue(OpInit, 0, 0, 0);
    issue(OpFind, 0, 0, 0);
    issue(OpFind, 0, 65534, 0);
    issue(OpFind, 0, 65535, 0);
    issue(OpFind, 0, 65536, 0);
    issue(OpSubtract, 0, 9, 9);
    issue(OpSubtract, 0, 65536, 0);
    issue(OpUndef, 0, 1, 2);
    issue(OpSubtract, 0, 10, 20);
    issue(OpFind, 0, 15, 0);
    issue(OpFind, 0, 5, 0);
    issue(OpSubtract, 0, 0, 3);
    issue(OpSubtract, 0, 8, 12);
    issue(OpSubtract, 0, 60000, 65536);
    issue(OpSubtract, 0, 20, 30);
    for (int i = 0; i < 15; i++) issue(OpSubtract, 0, 100 + 4 * i, 102 + 4 * i);
    issue(OpSubtract, 0, 1000, 1001);
    issue(OpSubtract, 0, 0, 65536);
    issue(OpFind, 0, 50, 0);
    drain();

    set_limit(16'd0);
    issue(OpInit, 1, 0, 0);
    issue(OpFind, 1, 0, 0);
    issue(OpFind, 1, 1, 0);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_limit(16'hFFFF);
        1: set_limit(16'd0);
        2: set_limit(16'd65534);
        3: set_limit(16'd100);
        default: set_limit(16'($urandom));
      endcase
      idle_pct = (ph == 2) ? 0 : 27;
      for (int i = 0; i < 340; i++) random_item();
    end

    drain();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
